FILE: src/tbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbi_pkg
// Types, codes and sizes shared by the table bilinear interpolator modules.
// ----------------------------------------------------------------------------
package tbi_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_POINTS_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 24;

    localparam int Q2_W = 32;
    localparam int X_W  = 25;
    localparam int V_W  = 32;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ORDER   = 2'd3;

    typedef struct packed {
        logic [1:0]            mode;
        logic [Q2_W-1:0]       q2;
        logic [X_W-1:0]        x;
        logic signed [V_W-1:0] f1_in;
        logic signed [V_W-1:0] f2_in;
        logic signed [V_W-1:0] g1_in;
        logic signed [V_W-1:0] g2_in;
    } in_t;

    typedef struct packed {
        logic signed [V_W-1:0] f1_out;
        logic signed [V_W-1:0] f2_out;
        logic signed [V_W-1:0] g1_out;
        logic signed [V_W-1:0] g2_out;
        logic [1:0]            status;
    } out_t;

    typedef struct packed {
        logic            start;
        logic [Q2_W-1:0] num;
        logic [Q2_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                  start;
        logic signed [V_W-1:0] a;
        logic signed [V_W-1:0] b;
    } blend_req_t;

endpackage
`default_nettype wire

FILE: src/table_bilinear_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// clear, load and unused-mode items: result registered when the item is accepted
// query: linear scan for the bracket rows, then per row a linear point scan, a divide and
//   four blends, then a divide and four blends across q2
// one item at a time; the next item is taken once the result register is free
// reset empties the table through the row and point counters; no clearing pass
// ----------------------------------------------------------------------------
// table_bilinear_interpolator
// Rectilinear (q2, x) table with bilinear interpolation in fixed point.
// ----------------------------------------------------------------------------
module table_bilinear_interpolator
    import tbi_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire in_t  item,
    input  wire logic item_valid,
    output logic      item_stall,
    output out_t      result,
    output logic      result_valid,
    input  wire logic result_stall
);

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int RC_W   = $clog2(MAX_ROWS + 1);
    localparam int PT_AW  = $clog2(MAX_POINTS);
    localparam int PC_W   = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ROW_W  = 5'd1;
    localparam logic [4:0] S_ROW_CK = 5'd2;
    localparam logic [4:0] S_FA_W   = 5'd3;
    localparam logic [4:0] S_FA_CK  = 5'd4;
    localparam logic [4:0] S_FB_W   = 5'd5;
    localparam logic [4:0] S_FB_CK  = 5'd6;
    localparam logic [4:0] S_FC_W   = 5'd7;
    localparam logic [4:0] S_FC_CK  = 5'd8;
    localparam logic [4:0] S_PT_W   = 5'd9;
    localparam logic [4:0] S_PT_CK  = 5'd10;
    localparam logic [4:0] S_LA_W   = 5'd11;
    localparam logic [4:0] S_LA_CK  = 5'd12;
    localparam logic [4:0] S_LB_W   = 5'd13;
    localparam logic [4:0] S_LB_CK  = 5'd14;
    localparam logic [4:0] S_DIV    = 5'd15;
    localparam logic [4:0] S_BL_GO  = 5'd16;
    localparam logic [4:0] S_BL     = 5'd17;

    localparam logic [1:0] PH_ROW0 = 2'd0;
    localparam logic [1:0] PH_ROW1 = 2'd1;
    localparam logic [1:0] PH_Q2   = 2'd2;

    typedef struct packed {
        logic [X_W-1:0]        x;
        logic signed [V_W-1:0] f1;
        logic signed [V_W-1:0] f2;
        logic signed [V_W-1:0] g1;
        logic signed [V_W-1:0] g2;
    } pt_entry_t;

    // table memories
    logic [Q2_W-1:0]  row_key_mem   [MAX_ROWS];
    logic [PT_AW-1:0] row_start_mem [MAX_ROWS];
    pt_entry_t        pt_mem        [MAX_POINTS];
    logic [Q2_W-1:0]  row_key_rd;
    logic [PT_AW-1:0] row_start_rd;
    pt_entry_t        pt_rd;
    logic             row_we;
    logic             pt_we;
    pt_entry_t        pt_wdata;

    logic [4:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [1:0]        k_reg, k_next;
    logic [RC_W-1:0]   row_count_reg, row_count_next;
    logic [PC_W-1:0]   point_count_reg, point_count_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg, out_next;
    logic [Q2_W-1:0]   last_key_reg, last_key_next;
    logic [X_W-1:0]    last_x_reg, last_x_next;
    logic [Q2_W-1:0]   q2_reg, q2_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [RC_W-1:0]   idx_reg, idx_next;
    logic [ROW_AW-1:0] r0_reg, r0_next;
    logic [ROW_AW-1:0] row_addr_reg, row_addr_next;
    logic [PT_AW-1:0]  pt_addr_reg, pt_addr_next;
    logic [Q2_W-1:0]   k0_reg, k0_next;
    logic [Q2_W-1:0]   k1_reg, k1_next;
    logic [PC_W-1:0]   s0_reg, s0_next;
    logic [PC_W-1:0]   s1_reg, s1_next;
    logic [PC_W-1:0]   e1_reg, e1_next;
    logic [PC_W-1:0]   pb_reg, pb_next;
    logic [PC_W-1:0]   pe_reg, pe_next;
    logic [PC_W-1:0]   p_reg, p_next;
    logic [PT_AW-1:0]  lo_reg, lo_next;
    logic [X_W-1:0]    xa_reg, xa_next;
    logic [FRAC_BITS:0] w_reg, w_next;
    logic signed [V_W-1:0] va_reg  [4];
    logic signed [V_W-1:0] va_next [4];
    logic signed [V_W-1:0] vb_reg  [4];
    logic signed [V_W-1:0] vb_next [4];
    logic signed [V_W-1:0] rv0_reg [4];
    logic signed [V_W-1:0] rv0_next[4];
    logic signed [V_W-1:0] rv1_reg [4];
    logic signed [V_W-1:0] rv1_next[4];
    logic signed [V_W-1:0] fin_reg [4];
    logic signed [V_W-1:0] fin_next[4];

    logic               accept;
    logic               go_outside;
    logic               order_bad;
    logic               new_row;
    logic               full;
    logic [RC_W-1:0]    idx_inc;
    logic [RC_W-1:0]    idx_dec;
    logic [RC_W-1:0]    rc_less2;
    logic [RC_W-1:0]    r0_plus2;
    logic [PC_W-1:0]    p_inc;
    logic [PC_W-1:0]    p_dec;
    logic [PC_W-1:0]    pe_less2;
    logic [X_W-1:0]     x_diff;
    logic [X_W-1:0]     x_span;

    div_req_t           div_req;
    logic [FRAC_BITS:0] div_quo;
    logic               div_done;
    blend_req_t         blend_req;
    logic signed [V_W-1:0] blend_res;
    logic               blend_done;

    tbi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .quo   (div_quo),
        .done  (div_done)
    );

    tbi_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (blend_req),
        .w     (w_reg),
        .res   (blend_res),
        .done  (blend_done)
    );

    assign item_stall   = (state_reg != S_IDLE) || (out_valid_reg && result_stall);
    assign accept       = item_valid && !item_stall;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    assign order_bad = (row_count_reg != '0) &&
                       ((item.q2 < last_key_reg) ||
                        ((item.q2 == last_key_reg) && (item.x <= last_x_reg)));
    assign new_row   = (row_count_reg == '0) || (item.q2 != last_key_reg);
    assign full      = (point_count_reg >= PC_W'(MAX_POINTS)) ||
                       (new_row && (row_count_reg >= RC_W'(MAX_ROWS)));

    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign rc_less2 = row_count_reg - RC_W'(2);
    assign r0_plus2 = RC_W'(r0_reg) + RC_W'(2);
    assign p_inc    = p_reg + 1'b1;
    assign p_dec    = p_reg - 1'b1;
    assign pe_less2 = pe_reg - PC_W'(2);
    assign x_diff   = x_reg - xa_reg;
    assign x_span   = pt_rd.x - xa_reg;

    assign pt_wdata = '{x: item.x, f1: item.f1_in, f2: item.f2_in,
                        g1: item.g1_in, g2: item.g2_in};

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        k_next           = k_reg;
        row_count_next   = row_count_reg;
        point_count_next = point_count_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        last_key_next    = last_key_reg;
        last_x_next      = last_x_reg;
        q2_next          = q2_reg;
        x_next           = x_reg;
        idx_next         = idx_reg;
        r0_next          = r0_reg;
        row_addr_next    = row_addr_reg;
        pt_addr_next     = pt_addr_reg;
        k0_next          = k0_reg;
        k1_next          = k1_reg;
        s0_next          = s0_reg;
        s1_next          = s1_reg;
        e1_next          = e1_reg;
        pb_next          = pb_reg;
        pe_next          = pe_reg;
        p_next           = p_reg;
        lo_next          = lo_reg;
        xa_next          = xa_reg;
        w_next           = w_reg;
        va_next          = va_reg;
        vb_next          = vb_reg;
        rv0_next         = rv0_reg;
        rv1_next         = rv1_reg;
        fin_next         = fin_reg;
        row_we           = 1'b0;
        pt_we            = 1'b0;
        div_req          = '0;
        blend_req        = '0;
        go_outside       = 1'b0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    q2_next  = item.q2;
                    x_next   = item.x;
                    out_next = '0;
                    unique case (item.mode)
                        MODE_CLEAR:
                        begin
                            row_count_next   = '0;
                            point_count_next = '0;
                            out_valid_next   = 1'b1;
                        end
                        MODE_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            if (order_bad)
                            begin
                                out_next.status = ST_ORDER;
                            end
                            else if (full)
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                if (new_row)
                                begin
                                    row_we         = 1'b1;
                                    row_count_next = row_count_reg + 1'b1;
                                end
                                pt_we            = 1'b1;
                                point_count_next = point_count_reg + 1'b1;
                                last_key_next    = item.q2;
                                last_x_next      = item.x;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (row_count_reg < RC_W'(2))
                            begin
                                go_outside = 1'b1;
                            end
                            else
                            begin
                                idx_next      = '0;
                                row_addr_next = '0;
                                state_next    = S_ROW_W;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ROW_W:
            begin
                state_next = S_ROW_CK;
            end
            S_ROW_CK:
            begin
                if (row_key_rd > q2_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        go_outside = 1'b1;
                    end
                    else
                    begin
                        r0_next       = idx_dec[ROW_AW-1:0];
                        row_addr_next = idx_dec[ROW_AW-1:0];
                        state_next    = S_FA_W;
                    end
                end
                else if (idx_inc == row_count_reg)
                begin
                    // every key at or below q2: only an exact hit on the last key brackets
                    if (row_key_rd == q2_reg)
                    begin
                        r0_next       = rc_less2[ROW_AW-1:0];
                        row_addr_next = rc_less2[ROW_AW-1:0];
                        state_next    = S_FA_W;
                    end
                    else
                    begin
                        go_outside = 1'b1;
                    end
                end
                else
                begin
                    idx_next      = idx_inc;
                    row_addr_next = idx_inc[ROW_AW-1:0];
                    state_next    = S_ROW_W;
                end
            end
            S_FA_W:
            begin
                state_next = S_FA_CK;
            end
            S_FA_CK:
            begin
                k0_next       = row_key_rd;
                s0_next       = PC_W'(row_start_rd);
                row_addr_next = r0_reg + 1'b1;
                state_next    = S_FB_W;
            end
            S_FB_W:
            begin
                state_next = S_FB_CK;
            end
            S_FB_CK:
            begin
                k1_next = row_key_rd;
                s1_next = PC_W'(row_start_rd);
                if (r0_plus2 < row_count_reg)
                begin
                    row_addr_next = r0_plus2[ROW_AW-1:0];
                    state_next    = S_FC_W;
                end
                else
                begin
                    e1_next      = point_count_reg;
                    phase_next   = PH_ROW0;
                    pb_next      = s0_reg;
                    pe_next      = PC_W'(row_start_rd);
                    p_next       = s0_reg;
                    pt_addr_next = s0_reg[PT_AW-1:0];
                    state_next   = S_PT_W;
                end
            end
            S_FC_W:
            begin
                state_next = S_FC_CK;
            end
            S_FC_CK:
            begin
                e1_next      = PC_W'(row_start_rd);
                phase_next   = PH_ROW0;
                pb_next      = s0_reg;
                pe_next      = s1_reg;
                p_next       = s0_reg;
                pt_addr_next = s0_reg[PT_AW-1:0];
                state_next   = S_PT_W;
            end
            S_PT_W:
            begin
                state_next = S_PT_CK;
            end
            S_PT_CK:
            begin
                if (pt_rd.x > x_reg)
                begin
                    if (p_reg == pb_reg)
                    begin
                        go_outside = 1'b1;
                    end
                    else
                    begin
                        lo_next      = p_dec[PT_AW-1:0];
                        pt_addr_next = p_dec[PT_AW-1:0];
                        state_next   = S_LA_W;
                    end
                end
                else if (p_inc == pe_reg)
                begin
                    if ((pt_rd.x == x_reg) && ((pe_reg - pb_reg) >= PC_W'(2)))
                    begin
                        lo_next      = pe_less2[PT_AW-1:0];
                        pt_addr_next = pe_less2[PT_AW-1:0];
                        state_next   = S_LA_W;
                    end
                    else
                    begin
                        go_outside = 1'b1;
                    end
                end
                else
                begin
                    p_next       = p_inc;
                    pt_addr_next = p_inc[PT_AW-1:0];
                    state_next   = S_PT_W;
                end
            end
            S_LA_W:
            begin
                state_next = S_LA_CK;
            end
            S_LA_CK:
            begin
                xa_next      = pt_rd.x;
                va_next[0]   = pt_rd.f1;
                va_next[1]   = pt_rd.f2;
                va_next[2]   = pt_rd.g1;
                va_next[3]   = pt_rd.g2;
                pt_addr_next = lo_reg + 1'b1;
                state_next   = S_LB_W;
            end
            S_LB_W:
            begin
                state_next = S_LB_CK;
            end
            S_LB_CK:
            begin
                vb_next[0]    = pt_rd.f1;
                vb_next[1]    = pt_rd.f2;
                vb_next[2]    = pt_rd.g1;
                vb_next[3]    = pt_rd.g2;
                div_req.start = 1'b1;
                div_req.num   = {{(Q2_W-X_W){1'b0}}, x_diff};
                div_req.den   = {{(Q2_W-X_W){1'b0}}, x_span};
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    w_next     = div_quo;
                    k_next     = '0;
                    state_next = S_BL_GO;
                end
            end
            S_BL_GO:
            begin
                blend_req.start = 1'b1;
                if (phase_reg == PH_Q2)
                begin
                    blend_req.a = rv0_reg[k_reg];
                    blend_req.b = rv1_reg[k_reg];
                end
                else
                begin
                    blend_req.a = va_reg[k_reg];
                    blend_req.b = vb_reg[k_reg];
                end
                state_next = S_BL;
            end
            S_BL:
            begin
                if (blend_done)
                begin
                    case (phase_reg)
                        PH_ROW0: rv0_next[k_reg] = blend_res;
                        PH_ROW1: rv1_next[k_reg] = blend_res;
                        default: fin_next[k_reg] = blend_res;
                    endcase
                    if (k_reg != 2'd3)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_BL_GO;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_ROW0:
                            begin
                                phase_next   = PH_ROW1;
                                pb_next      = s1_reg;
                                pe_next      = e1_reg;
                                p_next       = s1_reg;
                                pt_addr_next = s1_reg[PT_AW-1:0];
                                state_next   = S_PT_W;
                            end
                            PH_ROW1:
                            begin
                                phase_next    = PH_Q2;
                                div_req.start = 1'b1;
                                div_req.num   = q2_reg - k0_reg;
                                div_req.den   = k1_reg - k0_reg;
                                state_next    = S_DIV;
                            end
                            default:
                            begin
                                out_next.f1_out = fin_reg[0];
                                out_next.f2_out = fin_reg[1];
                                out_next.g1_out = fin_reg[2];
                                out_next.g2_out = blend_res;
                                out_next.status = ST_OK;
                                out_valid_next  = 1'b1;
                                state_next      = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go_outside)
        begin
            out_next        = '0;
            out_next.status = ST_OUTSIDE;
            out_valid_next  = 1'b1;
            state_next      = S_IDLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_key_mem[row_count_reg[ROW_AW-1:0]]   <= item.q2;
            row_start_mem[row_count_reg[ROW_AW-1:0]] <= point_count_reg[PT_AW-1:0];
        end
        row_key_rd   <= row_key_mem[row_addr_reg];
        row_start_rd <= row_start_mem[row_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[point_count_reg[PT_AW-1:0]] <= pt_wdata;
        end
        pt_rd <= pt_mem[pt_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_ROW0;
            k_reg           <= '0;
            row_count_reg   <= '0;
            point_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            k_reg           <= k_next;
            row_count_reg   <= row_count_next;
            point_count_reg <= point_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        last_key_reg <= last_key_next;
        last_x_reg   <= last_x_next;
        q2_reg       <= q2_next;
        x_reg        <= x_next;
        idx_reg      <= idx_next;
        r0_reg       <= r0_next;
        row_addr_reg <= row_addr_next;
        pt_addr_reg  <= pt_addr_next;
        k0_reg       <= k0_next;
        k1_reg       <= k1_next;
        s0_reg       <= s0_next;
        s1_reg       <= s1_next;
        e1_reg       <= e1_next;
        pb_reg       <= pb_next;
        pe_reg       <= pe_next;
        p_reg        <= p_next;
        lo_reg       <= lo_next;
        xa_reg       <= xa_next;
        w_reg        <= w_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        rv0_reg      <= rv0_next;
        rv1_reg      <= rv1_next;
        fin_reg      <= fin_next;
    end

    // a row always holds at least one point, and the point count stays within MAX_POINTS
    assert property (@(posedge clk) disable iff (!rst_n)
        (PC_W'(row_count_reg) <= point_count_reg) &&
        (point_count_reg <= PC_W'(MAX_POINTS)))
        else $error("row or point count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    assert property (@(posedge clk) disable iff (!rst_n)
        blend_done |-> (state_reg == S_BL))
        else $error("blend finished outside the blend step");

    // a result only appears after a transaction or at the end of a query
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(accept || (state_reg != S_IDLE)))
        else $error("result appeared without a transaction");

endmodule
`default_nettype wire

FILE: src/tbi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbi_div
// Radix-2 restoring divider for weights num * 2^FRAC_BITS / den, num <= den.
// ----------------------------------------------------------------------------
module tbi_div
    import tbi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    output logic [FRAC_BITS:0]    quo,
    output logic                  done
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [Q2_W-1:0]  rem_reg, rem_next;
    logic [Q2_W-1:0]  den_reg, den_next;
    logic [FRAC_BITS:0] quo_reg, quo_next;
    logic [Q2_W:0]    rem_shift;
    logic [Q2_W:0]    rem_sub;

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            den_next  = req.den;
            cnt_next  = CNT_W'(FRAC_BITS);
            busy_next = 1'b1;
            // integer bit is set when num is at least den, which for a weight means num equals den
            if (req.num >= req.den)
            begin
                rem_next = req.num - req.den;
                quo_next = (FRAC_BITS+1)'(1);
            end
            else
            begin
                rem_next = req.num;
                quo_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[Q2_W-1:0];
                quo_next = {quo_reg[FRAC_BITS-1:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[Q2_W-1:0];
                quo_next = {quo_reg[FRAC_BITS-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

FILE: src/tbi_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbi_blend
// Two-stage linear blend a + round((b - a) * w / 2^FRAC_BITS), half up.
// ----------------------------------------------------------------------------
module tbi_blend
    import tbi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire blend_req_t            req,
    input  wire logic [FRAC_BITS:0]    w,
    output logic signed [V_W-1:0]      res,
    output logic                       done
);

    localparam int PROD_W = V_W + 1 + FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic signed [V_W:0]          diff;
    logic signed [FRAC_BITS+1:0]  w_ext;
    logic signed [PROD_W-1:0]     prod;
    logic signed [PROD_W-1:0]     rounded;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [V_W-1:0]        a_reg;
    logic signed [V_W-1:0]        res_reg, res_next;
    logic                         stage_reg;
    logic                         done_reg;

    assign diff    = {req.b[V_W-1], req.b} - {req.a[V_W-1], req.a};
    assign w_ext   = {1'b0, w};
    assign prod    = diff * w_ext;
    assign rounded = (prod_reg + HALF) >>> FRAC_BITS;
    // the blend is convex, so the low word already holds the exact sum
    assign res_next = a_reg + rounded[V_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= req.start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= prod;
            a_reg    <= req.a;
        end
        if (stage_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule
`default_nettype wire
